// ===== rtl/sars_pkg.sv =====
// shared types and constants for the serial adc read sequencer
package sars_pkg;

  // sequence phases, one per serial clock half period
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START_LO = 4'd1,
    PH_START_HI = 4'd2,
    PH_SGL_LO   = 4'd3,
    PH_SGL_HI   = 4'd4,
    PH_ODD_LO   = 4'd5,
    PH_ODD_HI   = 4'd6,
    PH_REL_LO   = 4'd7,
    PH_MSB_HI   = 4'd8,
    PH_MSB_LO   = 4'd9,
    PH_LSB_HI   = 4'd10,
    PH_LSB_LO   = 4'd11
  } phase_t;

  // configuration register indexes
  typedef enum logic {
    CFG_HALF_PERIOD  = 1'b0,
    CFG_SINGLE_ENDED = 1'b1
  } cfg_idx_t;

  localparam logic [7:0] HALF_PERIOD_RST  = 8'd2;
  localparam logic       SINGLE_ENDED_RST = 1'b1;

  // input item
  typedef struct packed {
    logic start_req;
    logic channel;
    logic dout_level;
  } in_t;

  // result item
  typedef struct packed {
    logic       clk_level;
    logic       cs_n_level;
    logic       di_level;
    logic       di_drive_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] sample;
    logic       mismatch;
  } out_t;

  // sequencer control state
  typedef struct packed {
    phase_t     phase;
    logic [7:0] tick_count;
    logic       clock_reg;
    logic       latched_channel;
    logic       latched_sgl;
  } ctrl_t;

endpackage

// ===== rtl/serial_adc_read_sequencer.sv =====
// top level of the serial adc read sequencer
// Each input item is one system tick: the block advances the converter
// sequence by one tick and returns exactly one result item carrying the pin
// levels, busy, and on the final tick the done pulse with the sample. One
// item is taken per clock while in_stall is low; the tick's work is a single
// combinational step between the state registers and the result register, so
// the result is registered at the edge that takes the item. A result register
// plus one skid entry lets the input take one more item while the output is
// stalled; in_stall rises only when both hold an item. A conversion spans
// (2 * 3 + 1 + 2 * (2 * DATA_BITS)) half periods of half_period items each (zero
// counts as one), followed by one item that carries the done pulse. Configuration writes are always ready.
module serial_adc_read_sequencer #(
  parameter int DATA_BITS = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  sars_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output sars_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_index,
  input  logic [7:0]      cfg_data
);
  import sars_pkg::*;

  localparam int BW = $clog2(DATA_BITS);

  logic [7:0]           half_period_r;
  logic                 single_ended_r;
  ctrl_t                ctrl_r, ctrl_nxt;
  logic [DATA_BITS-1:0] msb_word_r, msb_word_nxt;
  logic [DATA_BITS-1:0] lsb_word_r, lsb_word_nxt;
  logic [BW-1:0]        bit_idx_r, bit_idx_nxt;
  out_t                 res;
  out_t                 out_r, skid_r;
  logic                 out_valid_r, skid_valid_r;
  logic                 in_acc;
  logic                 out_pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !skid_valid_r;
  assign out_pop   = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r  <= HALF_PERIOD_RST;
      single_ended_r <= SINGLE_ENDED_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_HALF_PERIOD:  half_period_r  <= cfg_data;
        CFG_SINGLE_ENDED: single_ended_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // one tick of sequencing
  sars_step #(.DATA_BITS(DATA_BITS)) u_step (
    .ctrl         (ctrl_r),
    .msb_word     (msb_word_r),
    .lsb_word     (lsb_word_r),
    .bit_idx      (bit_idx_r),
    .half_period  (half_period_r),
    .single_ended (single_ended_r),
    .in_item      (in_data),
    .ctrl_nxt     (ctrl_nxt),
    .msb_word_nxt (msb_word_nxt),
    .lsb_word_nxt (lsb_word_nxt),
    .bit_idx_nxt  (bit_idx_nxt),
    .res          (res)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r     <= '{phase: PH_IDLE, tick_count: 8'd0, clock_reg: 1'b0,
                      latched_channel: 1'b0, latched_sgl: 1'b0};
      msb_word_r <= '0;
      lsb_word_r <= '0;
      bit_idx_r  <= '0;
    end else if (in_acc) begin
      ctrl_r     <= ctrl_nxt;
      msb_word_r <= msb_word_nxt;
      lsb_word_r <= lsb_word_nxt;
      bit_idx_r  <= bit_idx_nxt;
    end
  end

  // result register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_valid_r && !out_pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_pop) begin
        out_r <= skid_r;
      end
    end else if (in_acc) begin
      if (out_valid_r && !out_pop) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

`ifndef SYNTHESIS
  // skid entry only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid without result register");

  // mismatch only on the done tick, with a zero sample
  a_mismatch_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.mismatch) |-> (out_r.done_res && out_r.sample == 8'd0))
    else $error("mismatch outside done tick or nonzero sample");

  // idle holds a cleared tick count
  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl_r.phase == PH_IDLE) |-> (ctrl_r.tick_count == 8'd0))
    else $error("tick count nonzero in idle");

  // bit index stays within the word
  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(bit_idx_r) < DATA_BITS))
    else $error("bit index out of range");
`endif

endmodule

// ===== rtl/sars_step.sv =====
// one tick of the sequencer: next state and pin levels from current state and inputs
module sars_step #(
  parameter int DATA_BITS = 8
) (
  input  sars_pkg::ctrl_t                  ctrl,
  input  logic [DATA_BITS-1:0]             msb_word,
  input  logic [DATA_BITS-1:0]             lsb_word,
  input  logic [$clog2(DATA_BITS)-1:0]     bit_idx,
  input  logic [7:0]                       half_period,
  input  logic                             single_ended,
  input  sars_pkg::in_t                    in_item,
  output sars_pkg::ctrl_t                  ctrl_nxt,
  output logic [DATA_BITS-1:0]             msb_word_nxt,
  output logic [DATA_BITS-1:0]             lsb_word_nxt,
  output logic [$clog2(DATA_BITS)-1:0]     bit_idx_nxt,
  output sars_pkg::out_t                   res
);
  import sars_pkg::*;

  localparam int BW = $clog2(DATA_BITS);
  localparam logic [BW-1:0] LAST_BIT = BW'(DATA_BITS - 1);

  logic [7:0] h;
  logic       done;
  logic       same;

  // zero half period counts as one tick
  assign h = (half_period == 8'd0) ? 8'd1 : half_period;

  // state advance
  always_comb begin
    ctrl_nxt     = ctrl;
    msb_word_nxt = msb_word;
    lsb_word_nxt = lsb_word;
    bit_idx_nxt  = bit_idx;
    done         = 1'b0;
    if (ctrl.phase == PH_IDLE) begin
      if (in_item.start_req) begin
        ctrl_nxt.latched_channel = in_item.channel;
        ctrl_nxt.latched_sgl     = single_ended;
        msb_word_nxt             = '0;
        lsb_word_nxt             = '0;
        bit_idx_nxt              = '0;
        ctrl_nxt.tick_count      = 8'd1;
        ctrl_nxt.phase           = PH_START_LO;
      end
    end else if (ctrl.tick_count < h) begin
      ctrl_nxt.tick_count = ctrl.tick_count + 8'd1;
    end else begin
      ctrl_nxt.tick_count = 8'd1;
      case (ctrl.phase)
        PH_START_LO: ctrl_nxt.phase = PH_START_HI;
        PH_START_HI: ctrl_nxt.phase = PH_SGL_LO;
        PH_SGL_LO:   ctrl_nxt.phase = PH_SGL_HI;
        PH_SGL_HI:   ctrl_nxt.phase = PH_ODD_LO;
        PH_ODD_LO:   ctrl_nxt.phase = PH_ODD_HI;
        PH_ODD_HI:   ctrl_nxt.phase = PH_REL_LO;
        PH_REL_LO: begin
          ctrl_nxt.phase = PH_MSB_HI;
          bit_idx_nxt    = '0;
        end
        PH_MSB_HI:   ctrl_nxt.phase = PH_MSB_LO;
        PH_MSB_LO: begin
          msb_word_nxt = {msb_word[DATA_BITS-2:0], in_item.dout_level};
          if (bit_idx == LAST_BIT) begin
            // last msb-first bit is also the first lsb-first bit
            lsb_word_nxt   = {in_item.dout_level, lsb_word[DATA_BITS-1:1]};
            bit_idx_nxt    = '0;
            ctrl_nxt.phase = PH_LSB_HI;
          end else begin
            bit_idx_nxt    = bit_idx + BW'(1);
            ctrl_nxt.phase = PH_MSB_HI;
          end
        end
        PH_LSB_HI:   ctrl_nxt.phase = PH_LSB_LO;
        PH_LSB_LO: begin
          if (bit_idx == LAST_BIT) begin
            ctrl_nxt.phase      = PH_IDLE;
            ctrl_nxt.tick_count = 8'd0;
            ctrl_nxt.clock_reg  = 1'b1;
            done                = 1'b1;
          end else begin
            lsb_word_nxt   = {in_item.dout_level, lsb_word[DATA_BITS-1:1]};
            bit_idx_nxt    = bit_idx + BW'(1);
            ctrl_nxt.phase = PH_LSB_HI;
          end
        end
        default: ctrl_nxt.phase = PH_IDLE;
      endcase
    end

    // pin levels follow the new phase
    res.cs_n_level      = 1'b0;
    res.di_level        = 1'b1;
    res.di_drive_enable = 1'b0;
    res.busy_res        = 1'b1;
    case (ctrl_nxt.phase)
      PH_START_LO: begin
        res.clk_level = 1'b0; res.di_drive_enable = 1'b1;
      end
      PH_START_HI: begin
        res.clk_level = 1'b1; res.di_drive_enable = 1'b1;
      end
      PH_SGL_LO: begin
        res.clk_level = 1'b0; res.di_level = ctrl_nxt.latched_sgl;
        res.di_drive_enable = 1'b1;
      end
      PH_SGL_HI: begin
        res.clk_level = 1'b1; res.di_level = ctrl_nxt.latched_sgl;
        res.di_drive_enable = 1'b1;
      end
      PH_ODD_LO: begin
        res.clk_level = 1'b0; res.di_level = ctrl_nxt.latched_channel;
        res.di_drive_enable = 1'b1;
      end
      PH_ODD_HI: begin
        res.clk_level = 1'b1; res.di_level = ctrl_nxt.latched_channel;
        res.di_drive_enable = 1'b1;
      end
      PH_MSB_HI, PH_LSB_HI:            res.clk_level = 1'b1;
      PH_REL_LO, PH_MSB_LO, PH_LSB_LO: res.clk_level = 1'b0;
      default: begin
        res.clk_level  = ctrl_nxt.clock_reg;
        res.cs_n_level = 1'b1;
        res.busy_res   = 1'b0;
      end
    endcase
    ctrl_nxt.clock_reg = res.clk_level;

    // result fields on the done tick
    same           = (msb_word_nxt == lsb_word_nxt);
    res.done_res   = done;
    res.sample     = (done && same) ? msb_word_nxt[7:0] : 8'd0;
    res.mismatch   = done && !same;
  end

endmodule
